/* hw/rtl/mbsp_pkg.sv */
// Shared types and constants for the MIDI byte stream parser.
// No dependencies; used by the parser core, the result register and the top level.
`timescale 1ns / 1ps

package mbsp_pkg;

  typedef enum logic [2:0] {
    KIND_CLOCK   = 3'd0,
    KIND_START   = 3'd1,
    KIND_CONT    = 3'd2,
    KIND_STOP    = 3'd3,
    KIND_SONGPOS = 3'd4,
    KIND_CHANNEL = 3'd5
  } mbsp_kind_e;

  localparam logic [7:0] RT_CLOCK    = 8'hF8;
  localparam logic [7:0] RT_START    = 8'hFA;
  localparam logic [7:0] RT_CONT     = 8'hFB;
  localparam logic [7:0] RT_STOP     = 8'hFC;
  localparam logic [7:0] SYS_SONGPOS = 8'hF2;
  localparam logic [7:0] SYS_FIRST   = 8'hF0;
  localparam logic [7:0] SYS_LAST    = 8'hF7;
  localparam logic [3:0] HI_PROGRAM  = 4'hC;
  localparam logic [3:0] HI_PRESSURE = 4'hD;

  typedef struct packed {
    mbsp_kind_e  kind;
    logic [31:0] tick_time;
    logic [14:0] song_position;
    logic [7:0]  status;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
  } mbsp_result_t;

endpackage

/* hw/rtl/mbsp_in_stage.sv */
// Input register stage: holds one received word until the parser takes it.
// No package dependencies.
`timescale 1ns / 1ps

module mbsp_in_stage (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] arrival_time_i,
  input  logic        take_i,
  output logic        valid_o,
  output logic [7:0]  rx_byte_o,
  output logic [31:0] arrival_time_o
);

  logic        valid_q;
  logic [7:0]  byte_q;
  logic [31:0] time_q;

  assign in_ready_o     = !valid_q || take_i;
  assign valid_o        = valid_q;
  assign rx_byte_o      = byte_q;
  assign arrival_time_o = time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
      time_q <= arrival_time_i;
    end
  end

endmodule

/* hw/rtl/mbsp_parse.sv */
// Parser core: running status, song position capture and real-time decode.
// Depends on mbsp_pkg for event kinds, byte codes and the result struct.
`timescale 1ns / 1ps

module mbsp_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            rx_byte_i,
  input  logic [31:0]           arrival_time_i,
  output logic                  emit_o,
  output mbsp_pkg::mbsp_result_t result_o
);

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_LOW  = 2'd1,
    PHASE_HIGH = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    BODY_NONE   = 2'd0,
    BODY_STATUS = 2'd1,
    BODY_FIRST  = 2'd2
  } body_e;

  phase_e      phase_q, phase_d;
  body_e       body_q, body_d;
  logic [7:0]  pos_low_q, pos_low_d;
  logic [7:0]  status_q, status_d;
  logic [6:0]  held_q, held_d;
  logic        two_byte;

  assign two_byte = (status_q[7:4] == mbsp_pkg::HI_PROGRAM) ||
                    (status_q[7:4] == mbsp_pkg::HI_PRESSURE);

  always_comb begin
    phase_d   = phase_q;
    body_d    = body_q;
    pos_low_d = pos_low_q;
    status_d  = status_q;
    held_d    = held_q;
    emit_o    = 1'b0;
    result_o  = '0;
    if (rx_byte_i inside {[mbsp_pkg::RT_CLOCK:8'hFF]}) begin
      case (rx_byte_i)
        mbsp_pkg::RT_CLOCK: begin
          emit_o             = 1'b1;
          result_o.kind      = mbsp_pkg::KIND_CLOCK;
          result_o.tick_time = arrival_time_i;
        end
        mbsp_pkg::RT_START: begin
          emit_o        = 1'b1;
          result_o.kind = mbsp_pkg::KIND_START;
        end
        mbsp_pkg::RT_CONT: begin
          emit_o        = 1'b1;
          result_o.kind = mbsp_pkg::KIND_CONT;
        end
        mbsp_pkg::RT_STOP: begin
          emit_o        = 1'b1;
          result_o.kind = mbsp_pkg::KIND_STOP;
        end
        default: emit_o = 1'b0;
      endcase
    end else if (rx_byte_i == mbsp_pkg::SYS_SONGPOS) begin
      phase_d = PHASE_LOW;
    end else if (phase_q == PHASE_LOW) begin
      pos_low_d = rx_byte_i;
      phase_d   = PHASE_HIGH;
    end else if (phase_q == PHASE_HIGH) begin
      phase_d                = PHASE_IDLE;
      emit_o                 = 1'b1;
      result_o.kind          = mbsp_pkg::KIND_SONGPOS;
      result_o.song_position = {rx_byte_i, 7'd0} | {7'd0, pos_low_q};
    end else begin
      phase_d = PHASE_IDLE;
      if (rx_byte_i inside {[mbsp_pkg::SYS_FIRST:mbsp_pkg::SYS_LAST]}) begin
        body_d = BODY_NONE;
      end else if (rx_byte_i[7]) begin
        status_d = rx_byte_i;
        body_d   = BODY_STATUS;
      end else begin
        case (body_q)
          BODY_STATUS: begin
            if (two_byte) begin
              emit_o              = 1'b1;
              result_o.kind       = mbsp_pkg::KIND_CHANNEL;
              result_o.status     = status_q;
              result_o.first_data = rx_byte_i[6:0];
            end else begin
              held_d = rx_byte_i[6:0];
              body_d = BODY_FIRST;
            end
          end
          BODY_FIRST: begin
            body_d               = BODY_STATUS;
            emit_o               = 1'b1;
            result_o.kind        = mbsp_pkg::KIND_CHANNEL;
            result_o.status      = status_q;
            result_o.first_data  = held_q;
            result_o.second_data = rx_byte_i[6:0];
          end
          default: body_d = BODY_NONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PHASE_IDLE;
      body_q    <= BODY_NONE;
      pos_low_q <= '0;
      status_q  <= '0;
      held_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      body_q    <= body_d;
      pos_low_q <= pos_low_d;
      status_q  <= status_d;
      held_q    <= held_d;
    end
  end

endmodule

/* hw/rtl/mbsp_out_stage.sv */
// Result register: holds one event word until the receiver takes it.
// Depends on mbsp_pkg for the result struct.
`timescale 1ns / 1ps

module mbsp_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  mbsp_pkg::mbsp_result_t result_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output mbsp_pkg::mbsp_result_t result_o
);

  logic                   valid_q;
  mbsp_pkg::mbsp_result_t result_q;

  assign room_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

/* hw/rtl/midi_byte_stream_parser_top.sv */
// MIDI byte stream parser: top level.
// Depends on mbsp_pkg, mbsp_in_stage, mbsp_parse and mbsp_out_stage.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one received MIDI byte with
//   its microsecond arrival time per word. Output channel
//   (out_valid_o/out_ready_i) gives at most one event word per input word:
//   clock tick (with timestamp), start, continue, stop, song position or a
//   completed channel message. Bytes that finish nothing give no word.
//   Ordering: an input word is registered in the input stage, decoded from
//   that register and its event is then registered in the result register.
//   Throughput: one word per cycle while the result register has room, set
//   by the single decode step between the input and result registers.
//   Reset: clears running status, song position capture and both stage
//   valid flags; the block accepts a word once reset is released.
//   Stall: while the output word waits, the input register holds one more
//   word, after which in_ready_o drops until the receiver takes the event.
`timescale 1ns / 1ps

module midi_byte_stream_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] arrival_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_kind_o,
  output logic [31:0] tick_time_o,
  output logic [14:0] song_position_o,
  output logic [7:0]  status_out_o,
  output logic [6:0]  first_data_out_o,
  output logic [6:0]  second_data_out_o
);

  logic                   stage_valid;
  logic [7:0]             stage_byte;
  logic [31:0]            stage_time;
  logic                   room;
  logic                   advance;
  logic                   emit;
  mbsp_pkg::mbsp_result_t parse_result;
  mbsp_pkg::mbsp_result_t out_result;

  assign advance = stage_valid && room;

  mbsp_in_stage u_in_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .arrival_time_i (arrival_time_i),
    .take_i         (advance),
    .valid_o        (stage_valid),
    .rx_byte_o      (stage_byte),
    .arrival_time_o (stage_time)
  );

  mbsp_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .rx_byte_i      (stage_byte),
    .arrival_time_i (stage_time),
    .emit_o         (emit),
    .result_o       (parse_result)
  );

  mbsp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && emit),
    .result_i    (parse_result),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign event_kind_o      = out_result.kind;
  assign tick_time_o       = out_result.tick_time;
  assign song_position_o   = out_result.song_position;
  assign status_out_o      = out_result.status;
  assign first_data_out_o  = out_result.first_data;
  assign second_data_out_o = out_result.second_data;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_channel_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_kind_o == mbsp_pkg::KIND_CHANNEL) |->
      (status_out_o[7] && status_out_o[7:4] != 4'hF))
    else $error("channel event without a channel status");

  a_songpos_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_kind_o == mbsp_pkg::KIND_SONGPOS) |->
      (tick_time_o == 32'd0 && status_out_o == 8'd0))
    else $error("song position event carries stray fields");
`endif

endmodule
